/* rtl/core/tbgd_pkg.sv */
// ----------------------------------------------------------------------------
// tbgd_pkg
// Shared types and constants for the two-button gesture detector.
// ----------------------------------------------------------------------------
package tbgd_pkg;

   // button phase; the unused code is handled as idle by the default arms
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DOWN = 2'd1,
      PH_LONG = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE         = 3'd0,
      EV_TOP_CLICK    = 3'd1,
      EV_TOP_LONG     = 3'd2,
      EV_BOTTOM_CLICK = 3'd3,
      EV_BOTTOM_LONG  = 3'd4,
      EV_BOTH         = 3'd5
   } event_type;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [1:0] REG_WINDOW     = 2'd2;

   localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd300;
   localparam logic [15:0] WINDOW_RESET     = 16'd500;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic [15:0] together_window;
   } cfg_type;

   // per-button event raised by one sample
   typedef struct packed {
      logic fire;
      logic is_long;
   } btn_event_type;

endpackage

/* rtl/core/tbgd_button.sv */
// ----------------------------------------------------------------------------
// tbgd_button
// Debounce and idle/down/long-fired machine for one button.
// ----------------------------------------------------------------------------
module tbgd_button import tbgd_pkg::*; #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [TIME_WIDTH-1:0] now,
   input  logic                  raw,
   input  cfg_type               cfg,
   input  logic                  force_long,
   output logic                  down,
   output logic [TIME_WIDTH-1:0] press_time,
   output btn_event_type         evt
);

   phase_type             phase_ff, phase_in;
   logic                  stable_ff, stable_in;
   logic                  prev_raw_ff;
   logic [TIME_WIDTH-1:0] change_time_ff, change_time_in;
   logic [TIME_WIDTH-1:0] press_time_ff, press_time_in;
   logic                  long_done_ff, long_done_in;

   logic                  long_hit;

   always_comb begin
      change_time_in = (raw != prev_raw_ff) ? now : change_time_ff;
      stable_in      = stable_ff;
      if ((now - change_time_in) >= TIME_WIDTH'(cfg.debounce_time)) begin
         stable_in = raw;
      end
      long_hit = (now - press_time_ff) >= TIME_WIDTH'(cfg.long_press_time);
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      press_time_in = press_time_ff;
      long_done_in  = long_done_ff;
      case (phase_ff)
         PH_DOWN: begin
            if (stable_in && !long_done_ff && long_hit) begin
               phase_in     = PH_LONG;
               long_done_in = 1'b1;
            end else if (!stable_in && !long_done_ff) begin
               phase_in = PH_IDLE;
            end
         end
         PH_LONG: begin
            if (!stable_in) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            if (stable_in) begin
               phase_in      = PH_DOWN;
               press_time_in = now;
               long_done_in  = 1'b0;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      evt = '0;
      if (phase_ff == PH_DOWN && !long_done_ff) begin
         if (stable_in && long_hit) begin
            evt.fire    = 1'b1;
            evt.is_long = 1'b1;
         end else if (!stable_in) begin
            evt.fire = 1'b1;
         end
      end
      down       = (phase_in == PH_DOWN);
      press_time = press_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         stable_ff      <= 1'b0;
         prev_raw_ff    <= 1'b0;
         change_time_ff <= '0;
         press_time_ff  <= '0;
         long_done_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff       <= force_long ? PH_LONG : phase_in;
         stable_ff      <= stable_in;
         prev_raw_ff    <= raw;
         change_time_ff <= change_time_in;
         press_time_ff  <= press_time_in;
         long_done_ff   <= long_done_in | force_long;
      end
   end

endmodule

/* rtl/core/tbgd_pair.sv */
// ----------------------------------------------------------------------------
// tbgd_pair
// Both-press detection across the two buttons, fired once per overlap.
// ----------------------------------------------------------------------------
module tbgd_pair import tbgd_pkg::*; #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  cfg_type               cfg,
   input  logic                  top_down,
   input  logic                  bottom_down,
   input  logic [TIME_WIDTH-1:0] top_press,
   input  logic [TIME_WIDTH-1:0] bottom_press,
   output logic                  fire
);

   logic                  pair_done_ff, pair_done_in;
   logic [TIME_WIDTH-1:0] dist_tb, dist_bt;
   logic                  near;

   always_comb begin
      dist_tb = top_press - bottom_press;
      dist_bt = bottom_press - top_press;
      // min of the two modular distances is within the window
      near = (dist_tb <= TIME_WIDTH'(cfg.together_window)) ||
             (dist_bt <= TIME_WIDTH'(cfg.together_window));
      fire = top_down && bottom_down && !pair_done_ff && near;
      pair_done_in = pair_done_ff | fire;
      if (!top_down && !bottom_down) begin
         pair_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_done_ff <= 1'b0;
      end else if (advance) begin
         pair_done_ff <= pair_done_in;
      end
   end

endmodule

/* rtl/core/two_button_gesture_detector_top.sv */
// ----------------------------------------------------------------------------
// two_button_gesture_detector_top
// Debounced click / long-press / both-press detector for two buttons.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_now_ms, req_top_pressed,
//          |           |                     | req_bottom_pressed
//  rsp     | out       | rsp_valid/rsp_stall | rsp_event_code
//  csr     | in/out    | APB, pready high    | 16-bit registers at 0, 4, 8
//
// One item per cycle while the result is not stalled; an accepted item is held
// in the input register and its result is loaded into the result register.
// The sample's debounce, phase and pair logic sits between those registers.
// Reset is synchronous and returns button state, configuration registers and valid flags to default.
// A stalled result holds; the input register keeps taking items as long as
// the result register can move.
// ----------------------------------------------------------------------------
module two_button_gesture_detector_top import tbgd_pkg::*; #(
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_now_ms,
   input  logic        req_top_pressed,
   input  logic        req_bottom_pressed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_code,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type               cfg_ff;
   logic                  in_valid_ff;
   logic [31:0]           in_now_ff;
   logic                  in_top_ff, in_bottom_ff;
   logic                  rsp_valid_ff;
   event_type             rsp_event_ff, rsp_event_in;
   logic                  advance;
   logic [TIME_WIDTH-1:0] now;
   logic [1:0]            reg_index;

   logic                  top_down, bottom_down;
   logic [TIME_WIDTH-1:0] top_press, bottom_press;
   btn_event_type         top_evt, bottom_evt;
   logic                  both_fire;

   // ---- configuration port ----
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= DEBOUNCE_RESET;
         cfg_ff.long_press_time <= LONG_PRESS_RESET;
         cfg_ff.together_window <= WINDOW_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_index)
            REG_DEBOUNCE:   cfg_ff.debounce_time   <= csr_pwdata[15:0];
            REG_LONG_PRESS: cfg_ff.long_press_time <= csr_pwdata[15:0];
            REG_WINDOW:     cfg_ff.together_window <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_DEBOUNCE:   csr_prdata = {16'd0, cfg_ff.debounce_time};
         REG_LONG_PRESS: csr_prdata = {16'd0, cfg_ff.long_press_time};
         REG_WINDOW:     csr_prdata = {16'd0, cfg_ff.together_window};
         default:        csr_prdata = '0;
      endcase
   end

   // ---- handshake ----
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_code = rsp_event_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_now_ff    <= req_now_ms;
         in_top_ff    <= req_top_pressed;
         in_bottom_ff <= req_bottom_pressed;
      end
   end

   assign now = TIME_WIDTH'(in_now_ff);

   // ---- per-sample logic ----
   tbgd_button #(.TIME_WIDTH(TIME_WIDTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .now        (now),
      .raw        (in_top_ff),
      .cfg        (cfg_ff),
      .force_long (both_fire),
      .down       (top_down),
      .press_time (top_press),
      .evt        (top_evt)
   );

   tbgd_button #(.TIME_WIDTH(TIME_WIDTH)) u_bottom (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .now        (now),
      .raw        (in_bottom_ff),
      .cfg        (cfg_ff),
      .force_long (both_fire),
      .down       (bottom_down),
      .press_time (bottom_press),
      .evt        (bottom_evt)
   );

   tbgd_pair #(.TIME_WIDTH(TIME_WIDTH)) u_pair (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cfg          (cfg_ff),
      .top_down     (top_down),
      .bottom_down  (bottom_down),
      .top_press    (top_press),
      .bottom_press (bottom_press),
      .fire         (both_fire)
   );

   // later events win: top, then bottom, then both
   always_comb begin
      rsp_event_in = EV_NONE;
      if (top_evt.fire) begin
         rsp_event_in = top_evt.is_long ? EV_TOP_LONG : EV_TOP_CLICK;
      end
      if (bottom_evt.fire) begin
         rsp_event_in = bottom_evt.is_long ? EV_BOTTOM_LONG : EV_BOTTOM_CLICK;
      end
      if (both_fire) begin
         rsp_event_in = EV_BOTH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff <= rsp_event_in;
      end
   end

endmodule

/* test/tb_two_button_gesture_detector_top.sv */
// ----------------------------------------------------------------------------
// tb_two_button_gesture_detector_top
// Self-checking bench for the two-button gesture detector. A scoreboard
// class mirrors the debounce, phase and pair logic of both buttons and
// queues the expected event of every accepted sample. Directed gestures
// come first, then random press/release segments with bounce, noise and
// timestamp wraps. These run under several register settings and several
// sender/receiver idle patterns, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_two_button_gesture_detector_top;
   import tbgd_pkg::*;

   typedef struct {
      phase_type  phase;
      bit         stable;
      bit         prev_raw;
      bit [31:0]  change_at;
      bit [31:0]  press_at;
      bit         long_done;
   } button_state_type;

   class gesture_scoreboard;
      bit [15:0]        settle_ms;
      bit [15:0]        long_ms;
      bit [15:0]        window_ms;
      button_state_type top_btn;
      button_state_type bot_btn;
      bit               pair_done;
      event_type        pending[$];
      int               errors;

      function new();
         settle_ms   = DEBOUNCE_RESET;
         long_ms     = LONG_PRESS_RESET;
         window_ms   = WINDOW_RESET;
         top_btn     = '{PH_IDLE, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0};
         bot_btn     = '{PH_IDLE, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0};
         pair_done   = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(bit [1:0] idx, bit [15:0] value);
         case (idx)
            REG_DEBOUNCE:   settle_ms = value;
            REG_LONG_PRESS: long_ms   = value;
            REG_WINDOW:     window_ms = value;
            default: ;
         endcase
      endfunction

      function void step_button(inout button_state_type btn, input bit [31:0] now,
                                input bit raw, input event_type click_ev,
                                input event_type long_ev, inout event_type ev);
         bit [31:0] since_change;
         bit [31:0] since_press;
         if (raw != btn.prev_raw) begin
            btn.prev_raw  = raw;
            btn.change_at = now;
         end
         since_change = now - btn.change_at;
         if (since_change >= {16'd0, settle_ms})
            btn.stable = raw;
         since_press = now - btn.press_at;
         case (btn.phase)
            PH_DOWN: begin
               if (btn.stable && !btn.long_done && since_press >= {16'd0, long_ms}) begin
                  ev            = long_ev;
                  btn.long_done = 1'b1;
                  btn.phase     = PH_LONG;
               end
               if (!btn.stable && !btn.long_done) begin
                  ev        = click_ev;
                  btn.phase = PH_IDLE;
               end
            end
            PH_LONG: begin
               if (!btn.stable)
                  btn.phase = PH_IDLE;
            end
            default: begin
               if (btn.stable) begin
                  btn.phase     = PH_DOWN;
                  btn.press_at  = now;
                  btn.long_done = 1'b0;
               end
            end
         endcase
      endfunction

      function void note_sample(bit [31:0] now, bit top_raw, bit bot_raw);
         event_type ev;
         bit        top_down;
         bit        bot_down;
         bit [31:0] gap_a;
         bit [31:0] gap_b;
         bit [31:0] gap;
         ev = EV_NONE;
         step_button(top_btn, now, top_raw, EV_TOP_CLICK, EV_TOP_LONG, ev);
         step_button(bot_btn, now, bot_raw, EV_BOTTOM_CLICK, EV_BOTTOM_LONG, ev);
         top_down = (top_btn.phase == PH_DOWN);
         bot_down = (bot_btn.phase == PH_DOWN);
         if (top_down && bot_down && !pair_done) begin
            // distance between press starts, shortest way around the wrap
            gap_a = top_btn.press_at - bot_btn.press_at;
            gap_b = bot_btn.press_at - top_btn.press_at;
            gap   = (gap_a < gap_b) ? gap_a : gap_b;
            if (gap <= {16'd0, window_ms}) begin
               ev                = EV_BOTH;
               pair_done         = 1'b1;
               top_btn.long_done = 1'b1;
               bot_btn.long_done = 1'b1;
               top_btn.phase     = PH_LONG;
               bot_btn.phase     = PH_LONG;
            end
         end
         if (!top_down && !bot_down)
            pair_done = 1'b0;
         pending.push_back(ev);
      endfunction

      function void check_event(logic [2:0] got);
         event_type want;
         if (pending.size() == 0) begin
            $error("event_code: expected none pending, actual %0d", got);
            errors++;
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               $error("event_code: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_now_ms = 32'd0;
   logic        req_top_pressed = 1'b0;
   logic        req_bottom_pressed = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_code;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gesture_scoreboard sb = new();

   int        send_idle_pct = 0;
   int        stall_pct = 0;
   logic      hold_req = 1'b0;
   int        hold_left = 0;
   int        items_sent = 0;
   bit [31:0] stamp = 32'd0;
   bit        top_lvl = 1'b0;
   bit        bot_lvl = 1'b0;

   two_button_gesture_detector_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_now_ms         (req_now_ms),
      .req_top_pressed    (req_top_pressed),
      .req_bottom_pressed (req_bottom_pressed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_code     (rsp_event_code),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("end of test: mismatches");
      $finish;
   end

   // result side: check accepted items, then pick the next stall level
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_event(rsp_event_code);
         if (hold_req && hold_left == 0)
            hold_left = 300;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic offer_sample(input bit [31:0] now, input bit top_raw, input bit bot_raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_now_ms         <= now;
      req_top_pressed    <= top_raw;
      req_bottom_pressed <= bot_raw;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_sample(now, top_raw, bot_raw);
      items_sent++;
   endtask

   // sample at an absolute timestamp
   task automatic sample_at(input bit [31:0] now, input bit top_raw, input bit bot_raw);
      stamp = now;
      offer_sample(now, top_raw, bot_raw);
   endtask

   task automatic csr_write(input bit [3:0] addr, input bit [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {16'($urandom_range(16'hFFFF, 0)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.write_reg(addr[3:2], value);
   endtask

   task automatic csr_check(input bit [3:0] addr, input bit [15:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata[15:0] !== want) begin
         $error("prdata: expected %0d, actual %0d", want, csr_prdata[15:0]);
         sb.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_regs(input bit [15:0] deb, input bit [15:0] lng, input bit [15:0] win);
      csr_write({REG_DEBOUNCE, 2'b00}, deb);
      csr_write({REG_LONG_PRESS, 2'b00}, lng);
      csr_write({REG_WINDOW, 2'b00}, win);
      csr_check({REG_DEBOUNCE, 2'b00}, sb.settle_ms);
      csr_check({REG_LONG_PRESS, 2'b00}, sb.long_ms);
      csr_check({REG_WINDOW, 2'b00}, sb.window_ms);
   endtask

   // one press/release stretch: optional bounce, then held levels for a while; or a burst of random levels
   task automatic run_segment(input int scale);
      int kind;
      int pick;
      int hold;
      int elapsed;
      int step;
      int n;
      kind = $urandom_range(99);
      if (kind < 3) begin
         stamp = (kind == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(scale);
      end
      if (kind < 10) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            stamp += $urandom_range(0, scale);
            top_lvl = 1'($urandom_range(1));
            bot_lvl = 1'($urandom_range(1));
            offer_sample(stamp, top_lvl, bot_lvl);
         end
      end else begin
         pick = $urandom_range(9);
         if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               stamp += $urandom_range(0, scale / 8);
               offer_sample(stamp, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
         end
         top_lvl = (pick == 4 || pick == 5 || pick >= 8);
         bot_lvl = (pick == 6 || pick == 7 || pick >= 8);
         hold    = $urandom_range(0, 2 * scale + 2);
         elapsed = 0;
         do begin
            step = $urandom_range(0, scale / 6 + 1);
            stamp += step;
            elapsed += step;
            offer_sample(stamp, top_lvl, bot_lvl);
         end while (elapsed < hold);
      end
   endtask

   task automatic run_directed();
      sample_at(32'd0, 1'b0, 1'b0);
      // top click
      sample_at(32'd100, 1'b1, 1'b0);
      sample_at(32'd130, 1'b1, 1'b0);
      sample_at(32'd200, 1'b0, 1'b0);
      sample_at(32'd230, 1'b0, 1'b0);
      // top long, then release
      sample_at(32'd1000, 1'b1, 1'b0);
      sample_at(32'd1030, 1'b1, 1'b0);
      sample_at(32'd1400, 1'b1, 1'b0);
      sample_at(32'd1500, 1'b0, 1'b0);
      sample_at(32'd1530, 1'b0, 1'b0);
      // bottom click with a bounce on the press
      sample_at(32'd2000, 1'b0, 1'b1);
      sample_at(32'd2005, 1'b0, 1'b0);
      sample_at(32'd2010, 1'b0, 1'b1);
      sample_at(32'd2040, 1'b0, 1'b1);
      sample_at(32'd2100, 1'b0, 1'b0);
      sample_at(32'd2130, 1'b0, 1'b0);
      // bottom long
      sample_at(32'd2500, 1'b0, 1'b1);
      sample_at(32'd2530, 1'b0, 1'b1);
      sample_at(32'd2900, 1'b0, 1'b1);
      sample_at(32'd2950, 1'b0, 1'b0);
      sample_at(32'd2980, 1'b0, 1'b0);
      // both together, then released
      sample_at(32'd3000, 1'b1, 1'b1);
      sample_at(32'd3030, 1'b1, 1'b1);
      sample_at(32'd3100, 1'b0, 1'b0);
      sample_at(32'd3130, 1'b0, 1'b0);
      // pair straddling the timestamp wrap
      sample_at(32'hFFFF_FFF0, 1'b1, 1'b0);
      sample_at(32'hFFFF_FFFF, 1'b1, 1'b0);
      sample_at(32'h0000_0010, 1'b1, 1'b1);
      sample_at(32'h0000_0030, 1'b1, 1'b1);
      sample_at(32'h0000_0100, 1'b0, 1'b0);
      sample_at(32'h0000_0130, 1'b0, 1'b0);
      top_lvl = 1'b0;
      bot_lvl = 1'b0;
   endtask

   initial begin
      int scale;
      int target;
      int mode;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      drain();

      for (int phase_no = 1; phase_no <= 8; phase_no++) begin
         case (phase_no)
            1: set_regs(16'd0, 16'd0, 16'd0);
            2: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: begin
               set_regs(16'($urandom_range(0, 8)), 16'($urandom_range(0, 60)),
                        16'($urandom_range(0, 40)));
               // index past the last register: no effect
               csr_write(4'd12, 16'($urandom_range(16'hFFFF, 0)));
               csr_check({REG_WINDOW, 2'b00}, sb.window_ms);
            end
            4: set_regs(DEBOUNCE_RESET, LONG_PRESS_RESET, WINDOW_RESET);
            8: set_regs(16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)),
                        16'($urandom_range(16'hFFFF, 0)));
            default: set_regs(16'($urandom_range(0, 100)), 16'($urandom_range(0, 1000)),
                              16'($urandom_range(0, 1000)));
         endcase
         mode = phase_no % 4;
         send_idle_pct = (mode == 1) ? 50 : (mode == 3) ? 31 : 0;
         stall_pct    <= (mode == 2) ? 50 : (mode == 3) ? 31 : 0;
         scale = int'(sb.settle_ms);
         if (sb.long_ms > scale) scale = int'(sb.long_ms);
         if (sb.window_ms > scale) scale = int'(sb.window_ms);
         if (scale < 4) scale = 4;
         if (phase_no == 4) begin
            // long receiver hold-off while items keep coming
            hold_req <= 1'b1;
            @(posedge clock);
            hold_req <= 1'b0;
         end
         target = items_sent + 170;
         while (items_sent < target)
            run_segment(scale);
         drain();
      end

      stall_pct <= 0;
      drain();
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
